### design/ipv4hc_pkg.sv
// ----------------------------------------------------------------------------
// IPv4 header check package
// Shared types, constants and the keepalive pattern for the header checker.
// ----------------------------------------------------------------------------
`default_nettype none

package ipv4hc_pkg;

    // Verdict codes as they appear on the status output.
    typedef enum logic [1:0] {
        ST_IPV4   = 2'd0,
        ST_PING   = 2'd1,
        ST_REJECT = 2'd2
    } t_status;

    // Version nibble values of the first header byte.
    localparam logic [3:0] VER_PING = 4'h0;
    localparam logic [3:0] VER_IPV4 = 4'h4;

    // Header lengths in bytes.
    localparam logic [5:0] PING_LEN       = 6'd20;
    localparam logic [5:0] IPV4_MIN_BYTES = 6'd20;

    // Byte positions of the checksum field.
    localparam logic [5:0] CSUM_HI_IDX = 6'd10;
    localparam logic [5:0] CSUM_LO_IDX = 6'd11;

    // Byte positions of the total length field.
    localparam logic [5:0] LEN_HI_IDX = 6'd2;
    localparam logic [5:0] LEN_LO_IDX = 6'd3;

    // One input word as it sits in the input register.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_req;
    } t_in_word;

    // One result word handed to the output register.
    typedef struct packed {
        logic        valid;
        t_status     status;
        logic [15:0] total_length;
    } t_result;

    // Expected keepalive byte at a given position.
    function automatic logic [7:0] keepalive_byte(input logic [4:0] idx);
        logic [7:0] val;
        case (idx)
            5'd0:    val = 8'h00;
            5'd1:    val = 8'hf6;
            5'd2:    val = 8'h8a;
            5'd3:    val = 8'h8d;
            5'd4:    val = 8'h6c;
            5'd5:    val = 8'hed;
            5'd6:    val = 8'h5b;
            5'd7:    val = 8'h98;
            5'd8:    val = 8'ha0;
            5'd9:    val = 8'hb4;
            5'd10:   val = 8'hf2;
            5'd11:   val = 8'hd3;
            5'd12:   val = 8'h66;
            5'd13:   val = 8'h81;
            5'd14:   val = 8'h76;
            5'd15:   val = 8'h8f;
            5'd16:   val = 8'he5;
            5'd17:   val = 8'hb7;
            5'd18:   val = 8'h43;
            5'd19:   val = 8'h46;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

### design/ipv4hc_in_reg.sv
// ----------------------------------------------------------------------------
// IPv4 header check input register
// Captures one input word per cycle and holds it while the pipeline stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4hc_in_reg (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire ipv4hc_pkg::t_in_word i_word,
    input  wire logic              i_advance,
    output logic                   o_valid,
    output ipv4hc_pkg::t_in_word   o_word
);

    logic                 r_valid;
    ipv4hc_pkg::t_in_word r_word;

    // The register takes a new word when it is empty or its word moves on.
    assign o_ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_word <= i_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

`default_nettype wire

### design/ipv4hc_core.sv
// ----------------------------------------------------------------------------
// IPv4 header check core
// Holds the per-header state, checks one byte per cycle while i_fire is high and forms the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4hc_core (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_fire,
    input  wire ipv4hc_pkg::t_in_word i_word,
    output ipv4hc_pkg::t_result       o_result
);

    // Header state.
    logic [5:0]  r_byte_index;
    logic        r_active;
    logic        r_packet_kind;
    logic [5:0]  r_header_bytes;
    logic [15:0] r_sum_acc;
    logic [7:0]  r_high_byte_hold;
    logic [15:0] r_stored_checksum;
    logic [15:0] r_length_field;
    logic        r_pattern_match;

    logic [5:0]  n_byte_index;
    logic        n_active;
    logic        n_packet_kind;
    logic [5:0]  n_header_bytes;
    logic [15:0] n_sum_acc;
    logic [7:0]  n_high_byte_hold;
    logic [15:0] n_stored_checksum;
    logic [15:0] n_length_field;
    logic        n_pattern_match;

    logic [7:0]  b;
    logic        start;
    logic        eff_active;
    logic        reject_ver;
    logic        done;
    logic        csum_byte;
    logic [7:0]  sum_val;
    logic [16:0] wide_sum;
    logic [5:0]  last_idx;
    logic [5:0]  span;

    always_comb begin
        b     = i_word.data_byte;
        start = i_word.start_req;

        // A start clears the header state before this byte is used.
        eff_active        = start || r_active;
        n_byte_index      = start ? 6'd0 : r_byte_index;
        n_sum_acc         = start ? 16'd0 : r_sum_acc;
        n_high_byte_hold  = start ? 8'd0 : r_high_byte_hold;
        n_stored_checksum = start ? 16'd0 : r_stored_checksum;
        n_length_field    = start ? 16'd0 : r_length_field;
        n_pattern_match   = start ? 1'b1 : r_pattern_match;
        n_packet_kind     = r_packet_kind;
        n_header_bytes    = r_header_bytes;
        n_active          = r_active;
        reject_ver        = 1'b0;
        wide_sum          = 17'd0;

        // The first byte picks the header kind from its version nibble.
        if (n_byte_index == 6'd0) begin
            if (b[7:4] == ipv4hc_pkg::VER_PING) begin
                n_packet_kind  = 1'b1;
                n_header_bytes = 6'd0;
            end else if (b[7:4] == ipv4hc_pkg::VER_IPV4) begin
                n_packet_kind  = 1'b0;
                n_header_bytes = {b[3:0], 2'b00};
            end else begin
                reject_ver = 1'b1;
            end
        end

        // Keepalive: every byte must match the fixed pattern.
        if (n_byte_index < ipv4hc_pkg::PING_LEN) begin
            if (b != ipv4hc_pkg::keepalive_byte(n_byte_index[4:0])) begin
                if (n_packet_kind) begin
                    n_pattern_match = 1'b0;
                end
            end
        end

        // IPv4: capture the length and checksum fields.
        if (!n_packet_kind) begin
            if (n_byte_index == ipv4hc_pkg::LEN_HI_IDX) begin
                n_length_field[15:8] = b;
            end else if (n_byte_index == ipv4hc_pkg::LEN_LO_IDX) begin
                n_length_field[7:0] = b;
            end else if (n_byte_index == ipv4hc_pkg::CSUM_HI_IDX) begin
                n_stored_checksum[15:8] = b;
            end else if (n_byte_index == ipv4hc_pkg::CSUM_LO_IDX) begin
                n_stored_checksum[7:0] = b;
            end
        end

        // IPv4: ones' complement sum over the header words, checksum as zero.
        csum_byte = (n_byte_index == ipv4hc_pkg::CSUM_HI_IDX) ||
                    (n_byte_index == ipv4hc_pkg::CSUM_LO_IDX);
        sum_val   = csum_byte ? 8'd0 : b;
        if (!n_packet_kind && (n_byte_index < n_header_bytes)) begin
            if (!n_byte_index[0]) begin
                n_high_byte_hold = sum_val;
            end else begin
                wide_sum  = {1'b0, n_sum_acc} + {1'b0, n_high_byte_hold, sum_val};
                n_sum_acc = wide_sum[15:0] + {15'd0, wide_sum[16]};
            end
        end

        // Position of the verdict byte.
        span = (n_header_bytes > ipv4hc_pkg::IPV4_MIN_BYTES) ?
               n_header_bytes : ipv4hc_pkg::IPV4_MIN_BYTES;
        last_idx = n_packet_kind ? (ipv4hc_pkg::PING_LEN - 6'd1) : (span - 6'd1);
        done     = (n_byte_index >= last_idx);

        // Verdict.
        o_result.valid        = i_fire && eff_active && (reject_ver || done);
        o_result.status       = ipv4hc_pkg::ST_REJECT;
        o_result.total_length = 16'd0;
        if (!reject_ver) begin
            if (n_packet_kind) begin
                if (n_pattern_match) begin
                    o_result.status       = ipv4hc_pkg::ST_PING;
                    o_result.total_length = {10'd0, ipv4hc_pkg::PING_LEN};
                end
            end else if (~n_sum_acc == n_stored_checksum) begin
                o_result.status       = ipv4hc_pkg::ST_IPV4;
                o_result.total_length = n_length_field;
            end
        end

        // A verdict ends the header; otherwise move to the next byte.
        if (eff_active) begin
            if (reject_ver || done) begin
                n_active = 1'b0;
            end else begin
                n_active     = 1'b1;
                n_byte_index = n_byte_index + 6'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_index      <= 6'd0;
            r_active          <= 1'b0;
            r_packet_kind     <= 1'b0;
            r_header_bytes    <= 6'd0;
            r_sum_acc         <= 16'd0;
            r_high_byte_hold  <= 8'd0;
            r_stored_checksum <= 16'd0;
            r_length_field    <= 16'd0;
            r_pattern_match   <= 1'b1;
        end else if (i_fire && eff_active) begin
            r_byte_index      <= n_byte_index;
            r_active          <= n_active;
            r_packet_kind     <= n_packet_kind;
            r_header_bytes    <= n_header_bytes;
            r_sum_acc         <= n_sum_acc;
            r_high_byte_hold  <= n_high_byte_hold;
            r_stored_checksum <= n_stored_checksum;
            r_length_field    <= n_length_field;
            r_pattern_match   <= n_pattern_match;
        end
    end

endmodule

`default_nettype wire

### design/ipv4hc_out_reg.sv
// ----------------------------------------------------------------------------
// IPv4 header check output register
// Holds one verdict word until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4hc_out_reg (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire ipv4hc_pkg::t_result i_result,
    output logic                     o_load,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output logic [1:0]               o_status,
    output logic [15:0]              o_total_length
);

    logic        r_valid;
    logic [1:0]  r_status;
    logic [15:0] r_total_length;

    // The register can be loaded when empty or being emptied this cycle.
    assign o_load = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_load) begin
            r_valid <= i_result.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_load && i_result.valid) begin
            r_status       <= i_result.status;
            r_total_length <= i_result.total_length;
        end
    end

    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_total_length = r_total_length;

endmodule

`default_nettype wire

### design/ipv4_header_check_and_length_top.sv
// ----------------------------------------------------------------------------
// IPv4 header check and length, top level
// Checks IPv4 header checksums and keepalive headers byte by byte.
// ----------------------------------------------------------------------------
// Usage:
// Header bytes enter on the input channel (i_in_valid / o_in_ready), one word
// per byte, with i_start_req high on the first byte of each header. A word
// with the start flag clear while no header is open is dropped.
// One verdict word leaves on the output channel (o_out_valid / i_out_ready)
// per header: after the first byte for an unknown version, after byte 20 for
// a keepalive header, after byte max(IHL*4, 20) for IPv4. Status 0 gives the
// total length from bytes 2-3, status 1 gives 20, status 2 gives 0.
// The verdict byte waits in the input register, the core checks it
// combinationally, and its verdict is loaded into the output register, which
// drives o_out_valid. The core checks one byte per cycle, so while the
// receiver does not stall a new word is taken every cycle.
// When the receiver stalls, the output register holds its word and the input
// register holds one more; the input side then deasserts o_in_ready.
// Reset clears both registers and closes any open header.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4_header_check_and_length_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_start_req,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_status,
    output logic [15:0]      o_total_length
);

    ipv4hc_pkg::t_in_word in_word;
    ipv4hc_pkg::t_in_word held_word;
    ipv4hc_pkg::t_result  result;
    logic                 held_valid;
    logic                 out_load;
    logic                 fire;

    assign in_word.data_byte = i_data_byte;
    assign in_word.start_req = i_start_req;

    // The held word is checked whenever the output register can take a result.
    assign fire = held_valid && out_load;

    ipv4hc_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .i_word    (in_word),
        .i_advance (out_load),
        .o_valid   (held_valid),
        .o_word    (held_word)
    );

    ipv4hc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_word   (held_word),
        .o_result (result)
    );

    ipv4hc_out_reg u_out_reg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_result       (result),
        .o_load         (out_load),
        .o_valid        (o_out_valid),
        .i_ready        (i_out_ready),
        .o_status       (o_status),
        .o_total_length (o_total_length)
    );

endmodule

`default_nettype wire

### dv/tb.sv
// ----------------------------------------------------------------------------
// IPv4 header checker testbench
// Feeds header words into the checker with random idle cycles on both
// channels. Each verdict is compared with a behavioral model of the checker
// that is kept in this file. A short table of directed words runs first. Then
// come random headers: valid and corrupted IPv4, short IHL, keepalive, other
// versions, and headers that are cut short by a new start.
// ----------------------------------------------------------------------------
module tb;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 8;
    localparam int WORD_TARGET  = 1700;
    localparam int IDLE_LIMIT   = 500;
    localparam int DRAIN_CYCLES = 16;
    localparam int TABLE_ROWS   = 26;

    typedef struct {
        ipv4hc_pkg::t_status status;
        logic [15:0]         total_length;
    } t_verdict;

    typedef struct {
        logic [7:0]          data_byte;
        logic                start_req;
        bit                  has_verdict;
        ipv4hc_pkg::t_status status;
        logic [15:0]         total_length;
    } t_dir_row;

    // DUT ports.
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_start_req = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [1:0]  o_status;
    logic [15:0] o_total_length;

    // Keepalive header as it must appear on the link.
    logic [7:0] ka_pattern [0:19] = '{
        8'h00, 8'hf6, 8'h8a, 8'h8d, 8'h6c, 8'hed, 8'h5b, 8'h98, 8'ha0, 8'hb4,
        8'hf2, 8'hd3, 8'h66, 8'h81, 8'h76, 8'h8f, 8'he5, 8'hb7, 8'h43, 8'h46
    };

    // Directed words. A verdict is typed in only where it is obvious.
    t_dir_row dir_rows [0:TABLE_ROWS-1] = '{
        // Stray word right after reset: no header is open, so it is dropped.
        '{8'hFF, 1'b0, 1'b0, ipv4hc_pkg::ST_IPV4,   16'd0},
        // Unknown version is rejected on its first word.
        '{8'hFF, 1'b1, 1'b1, ipv4hc_pkg::ST_REJECT, 16'd0},
        // Stray word after a verdict.
        '{8'h00, 1'b0, 1'b0, ipv4hc_pkg::ST_IPV4,   16'd0},
        // Keepalive that is dropped by a new start after two words.
        '{8'h00, 1'b1, 1'b0, ipv4hc_pkg::ST_IPV4,   16'd0},
        '{8'hf6, 1'b0, 1'b0, ipv4hc_pkg::ST_IPV4,   16'd0},
        // Full keepalive header.
        '{8'h00, 1'b1, 1'b0, ipv4hc_pkg::ST_IPV4,   16'd0},
        '{8'hf6, 1'b0, 1'b0, ipv4hc_pkg::ST_IPV4,   16'd0},
        '{8'h8a, 1'b0, 1'b0, ipv4hc_pkg::ST_IPV4,   16'd0},
        '{8'h8d, 1'b0, 1'b0, ipv4hc_pkg::ST_IPV4,   16'd0},
        '{8'h6c, 1'b0, 1'b0, ipv4hc_pkg::ST_IPV4,   16'd0},
        '{8'hed, 1'b0, 1'b0, ipv4hc_pkg::ST_IPV4,   16'd0},
        '{8'h5b, 1'b0, 1'b0, ipv4hc_pkg::ST_IPV4,   16'd0},
        '{8'h98, 1'b0, 1'b0, ipv4hc_pkg::ST_IPV4,   16'd0},
        '{8'ha0, 1'b0, 1'b0, ipv4hc_pkg::ST_IPV4,   16'd0},
        '{8'hb4, 1'b0, 1'b0, ipv4hc_pkg::ST_IPV4,   16'd0},
        '{8'hf2, 1'b0, 1'b0, ipv4hc_pkg::ST_IPV4,   16'd0},
        '{8'hd3, 1'b0, 1'b0, ipv4hc_pkg::ST_IPV4,   16'd0},
        '{8'h66, 1'b0, 1'b0, ipv4hc_pkg::ST_IPV4,   16'd0},
        '{8'h81, 1'b0, 1'b0, ipv4hc_pkg::ST_IPV4,   16'd0},
        '{8'h76, 1'b0, 1'b0, ipv4hc_pkg::ST_IPV4,   16'd0},
        '{8'h8f, 1'b0, 1'b0, ipv4hc_pkg::ST_IPV4,   16'd0},
        '{8'he5, 1'b0, 1'b0, ipv4hc_pkg::ST_IPV4,   16'd0},
        '{8'hb7, 1'b0, 1'b0, ipv4hc_pkg::ST_IPV4,   16'd0},
        '{8'h43, 1'b0, 1'b0, ipv4hc_pkg::ST_IPV4,   16'd0},
        '{8'h46, 1'b0, 1'b1, ipv4hc_pkg::ST_PING,   16'd20},
        // IPv4 with IHL 0, left open; the first random header drops it.
        '{8'h40, 1'b1, 1'b0, ipv4hc_pkg::ST_IPV4,   16'd0}
    };

    // State of the behavioral checker model.
    logic [5:0]  hdr_pos;
    logic        hdr_open;
    logic        hdr_is_ka;
    logic [5:0]  ihl_bytes;
    logic [16:0] sum_run;
    logic [7:0]  word_hi;
    logic [15:0] csum_field;
    logic [15:0] len_field;
    logic        ka_ok;

    // Verdicts that are due, oldest first.
    t_verdict pending_verdicts [$];

    // Header under construction for the random part.
    logic [7:0] hdr_buf [0:63];
    int         hdr_len;

    int fail_count = 0;
    int idle_cycles = 0;
    int header_words = 0;
    int header_count = 0;
    int ipv4_seen = 0;
    int ping_seen = 0;
    int reject_seen = 0;

    ipv4_header_check_and_length_top uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_data_byte    (i_data_byte),
        .i_start_req    (i_start_req),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_total_length (o_total_length)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Advance the checker model by one accepted word and report its verdict.
    task automatic judge_word(input logic [7:0] b, input logic s,
                              output bit done, output t_verdict v);
        logic [5:0] last_pos;
        logic [5:0] span;
        logic [7:0] addend;
        done = 1'b0;
        v.status = ipv4hc_pkg::ST_REJECT;
        v.total_length = 16'd0;
        if (s) begin
            hdr_open = 1'b1;
            hdr_pos = 6'd0;
            sum_run = 17'd0;
            word_hi = 8'h00;
            csum_field = 16'h0000;
            len_field = 16'h0000;
            ka_ok = 1'b1;
        end
        if (!hdr_open) return;

        // The version nibble of the first word picks the header kind.
        if (hdr_pos == 6'd0) begin
            if (b[7:4] == ipv4hc_pkg::VER_PING) begin
                hdr_is_ka = 1'b1;
                ihl_bytes = 6'd0;
            end else if (b[7:4] == ipv4hc_pkg::VER_IPV4) begin
                hdr_is_ka = 1'b0;
                ihl_bytes = {b[3:0], 2'b00};
            end else begin
                hdr_open = 1'b0;
                done = 1'b1;
                return;
            end
        end

        if (hdr_is_ka) begin
            if (hdr_pos < 20 && b != ka_pattern[hdr_pos]) ka_ok = 1'b0;
            last_pos = ipv4hc_pkg::PING_LEN - 6'd1;
        end else begin
            // Length and checksum fields are taken even when IHL is short.
            case (hdr_pos)
                ipv4hc_pkg::LEN_HI_IDX:  len_field[15:8] = b;
                ipv4hc_pkg::LEN_LO_IDX:  len_field[7:0] = b;
                ipv4hc_pkg::CSUM_HI_IDX: csum_field[15:8] = b;
                ipv4hc_pkg::CSUM_LO_IDX: csum_field[7:0] = b;
                default: ;
            endcase
            // Ones' complement sum over IHL*4 bytes, checksum bytes as zero.
            if (hdr_pos < ihl_bytes) begin
                addend = (hdr_pos == ipv4hc_pkg::CSUM_HI_IDX ||
                          hdr_pos == ipv4hc_pkg::CSUM_LO_IDX) ? 8'h00 : b;
                if (!hdr_pos[0]) begin
                    word_hi = addend;
                end else begin
                    sum_run = sum_run + {1'b0, word_hi, addend};
                    if (sum_run[16]) sum_run = {1'b0, sum_run[15:0]} + 17'd1;
                end
            end
            span = (ihl_bytes > ipv4hc_pkg::IPV4_MIN_BYTES) ?
                   ihl_bytes : ipv4hc_pkg::IPV4_MIN_BYTES;
            last_pos = span - 6'd1;
        end

        if (hdr_pos >= last_pos) begin
            hdr_open = 1'b0;
            done = 1'b1;
            if (hdr_is_ka) begin
                if (ka_ok) begin
                    v.status = ipv4hc_pkg::ST_PING;
                    v.total_length = 16'(ipv4hc_pkg::PING_LEN);
                end
            end else if (~sum_run[15:0] == csum_field) begin
                v.status = ipv4hc_pkg::ST_IPV4;
                v.total_length = len_field;
            end
        end else begin
            hdr_pos = hdr_pos + 6'd1;
        end
    endtask

    // Hand one word over the input channel and run the model on it.
    task automatic send_word(input logic [7:0] b, input logic s, input bit no_idle,
                             output bit done, output t_verdict v);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_data_byte <= b;
        i_start_req <= s;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        judge_word(b, s, done, v);
    endtask

    // IPv4 header with a correct checksum, optionally with one byte damaged.
    task automatic build_ipv4(input int ihl, input bit corrupt);
        int unsigned acc;
        int pos;
        hdr_len = (ihl * 4 > 20) ? ihl * 4 : 20;
        for (int i = 0; i < hdr_len; i++) hdr_buf[i] = 8'($urandom);
        hdr_buf[0] = {ipv4hc_pkg::VER_IPV4, 4'(ihl)};
        acc = 0;
        for (int i = 0; i < ihl * 4; i += 2) begin
            if (i != ipv4hc_pkg::CSUM_HI_IDX) acc += {hdr_buf[i], hdr_buf[i+1]};
        end
        while (acc > 32'hFFFF) acc = (acc & 32'hFFFF) + (acc >> 16);
        {hdr_buf[ipv4hc_pkg::CSUM_HI_IDX], hdr_buf[ipv4hc_pkg::CSUM_LO_IDX]} = 16'(~acc);
        if (corrupt) begin
            pos = $urandom_range(1, hdr_len - 1);
            hdr_buf[pos] ^= 8'($urandom_range(1, 255));
        end
    endtask

    // Keepalive header, optionally with one byte damaged.
    task automatic build_keepalive(input bit corrupt);
        int pos;
        hdr_len = 20;
        for (int i = 0; i < 20; i++) hdr_buf[i] = ka_pattern[i];
        if (corrupt) begin
            pos = $urandom_range(0, 19);
            // Keep the version nibble of the first byte intact.
            if (pos == 0) hdr_buf[0] ^= 8'($urandom_range(1, 15));
            else hdr_buf[pos] ^= 8'($urandom_range(1, 255));
        end
    endtask

    // Stimulus: directed table, then random headers, then drain.
    initial begin : stimulus
        t_verdict v;
        bit       done;
        bit       no_idle;
        bit       cut;
        int       pick;
        int       trail;
        int       ver;

        hdr_pos = 6'd0;
        hdr_open = 1'b0;
        hdr_is_ka = 1'b0;
        ihl_bytes = 6'd0;
        sum_run = 17'd0;
        word_hi = 8'h00;
        csum_field = 16'h0000;
        len_field = 16'h0000;
        ka_ok = 1'b1;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words; typed verdicts take the place of the model's.
        for (int r = 0; r < TABLE_ROWS; r++) begin
            send_word(dir_rows[r].data_byte, dir_rows[r].start_req, 1'b0, done, v);
            if (dir_rows[r].has_verdict) begin
                v.status = dir_rows[r].status;
                v.total_length = dir_rows[r].total_length;
                pending_verdicts.push_back(v);
            end else if (done) begin
                pending_verdicts.push_back(v);
            end
        end

        // Random headers, mostly well formed.
        while (header_words < WORD_TARGET) begin
            no_idle = ($urandom_range(0, 3) == 0);
            cut = 1'b0;
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                build_ipv4(($urandom_range(0, 4) == 0) ? $urandom_range(6, 15) : 5, 1'b0);
            end else if (pick < 50) begin
                build_ipv4($urandom_range(5, 7), 1'b1);
            end else if (pick < 60) begin
                build_ipv4($urandom_range(0, 4), $urandom_range(0, 3) == 0);
            end else if (pick < 75) begin
                build_keepalive(1'b0);
            end else if (pick < 82) begin
                build_keepalive(1'b1);
            end else if (pick < 90) begin
                ver = $urandom_range(1, 14);
                if (ver >= 4) ver++;
                hdr_len = 1;
                hdr_buf[0] = {4'(ver), 4'($urandom)};
            end else begin
                // Header cut short; the next start drops it.
                if ($urandom_range(0, 1) == 0) build_keepalive(1'b0);
                else build_ipv4($urandom_range(5, 8), 1'b0);
                hdr_len = $urandom_range(1, hdr_len - 1);
                cut = 1'b1;
            end

            for (int i = 0; i < hdr_len; i++) begin
                send_word(hdr_buf[i], i == 0, no_idle, done, v);
                if (done) pending_verdicts.push_back(v);
            end
            header_words += hdr_len;
            header_count++;

            // Words after a verdict are dropped until the next start.
            trail = (!cut && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
            for (int i = 0; i < trail; i++) begin
                send_word(8'($urandom), 1'b0, no_idle, done, v);
                if (done) pending_verdicts.push_back(v);
            end
        end
        i_in_valid <= 1'b0;

        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d header words in %0d random headers after %0d directed words.",
                 header_words, header_count, TABLE_ROWS);
        $display("Verdicts checked: %0d IPv4, %0d keepalive, %0d rejected; %0d failures.",
                 ipv4_seen, ping_seen, reject_seen, fail_count);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Verdict receiver with random stalls, compared with the oldest due verdict.
    initial begin : verdict_sink
        t_verdict want;
        int       stall;
        bit       no_stall;
        no_stall = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 15) == 0) no_stall = !no_stall;
            stall = no_stall ? 0 : $urandom_range(0, 7);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            if (pending_verdicts.size() == 0) begin
                $error("unexpected verdict word: status %0d, total_length %0d",
                       o_status, o_total_length);
                fail_count++;
            end else begin
                want = pending_verdicts.pop_front();
                if (o_status !== want.status) begin
                    $error("status mismatch: expected %0d, actual %0d", want.status, o_status);
                    fail_count++;
                end
                if (o_total_length !== want.total_length) begin
                    $error("total_length mismatch: expected %0d, actual %0d",
                           want.total_length, o_total_length);
                    fail_count++;
                end
                case (want.status)
                    ipv4hc_pkg::ST_IPV4: ipv4_seen++;
                    ipv4hc_pkg::ST_PING: ping_seen++;
                    default: reject_seen++;
                endcase
            end
        end
    end

    // Watchdog: ends the run when no word moves on either channel for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no word moved for %0d cycles, %0d verdicts outstanding.",
                     IDLE_LIMIT, pending_verdicts.size());
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

### ipv4_header_check_and_length_top.f
design/ipv4hc_pkg.sv
design/ipv4hc_in_reg.sv
design/ipv4hc_core.sv
design/ipv4hc_out_reg.sv
design/ipv4_header_check_and_length_top.sv
dv/tb.sv
